// ===== rtl/dcps_pkg.sv =====
// shared types, constants and opcodes of the dominance closure point store
package dcps_pkg;

  localparam int DIMS_DEF       = 4;
  localparam int COORD_BITS_DEF = 16;
  localparam int CAPACITY_DEF   = 32;
  localparam int MAXD           = 4;
  localparam int FIELD_W        = 16;

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_CONTAINS = 3'd1,
    OP_UPWARD   = 3'd2,
    OP_LISTDOM  = 3'd3,
    OP_STATUS   = 3'd4,
    OP_LISTALL  = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_COMPACT,
    ST_REPLY
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;      // capture query word
    logic scan_start; // reset scan index
    logic scan_step;  // read next entry
    logic compact;    // rewrite store
    logic reply;      // drive single result
  } dcps_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic compact_done;
    logic is_list;
  } dcps_sts_t;

endpackage

// ===== rtl/dcps_ctrl.sv =====
// controller state machine of the point store
module dcps_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  dcps_pkg::dcps_sts_t sts,
  input  logic               do_write,
  output dcps_pkg::dcps_cmd_t cmd,
  output logic               busy
);
  import dcps_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = sts.is_list ? ST_IDLE : ST_DECIDE;
      end
      ST_DECIDE: begin
        if (do_write) begin
          cmd.scan_start = 1'b1;
          state_nxt = ST_COMPACT;
        end else state_nxt = ST_REPLY;
      end
      ST_COMPACT: begin
        cmd.compact = 1'b1;
        if (sts.compact_done) state_nxt = ST_REPLY;
      end
      ST_REPLY: begin
        cmd.reply = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ===== rtl/dcps_dp.sv =====
// datapath: point memory, dominance tests, compaction and result drive
module dcps_dp #(
  parameter int DIMS       = dcps_pkg::DIMS_DEF,
  parameter int COORD_BITS = dcps_pkg::COORD_BITS_DEF,
  parameter int CAPACITY   = dcps_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dcps_pkg::dcps_cmd_t           cmd,
  output dcps_pkg::dcps_sts_t           sts,
  output logic                          do_write,
  input  logic [3:0]                    mask,
  input  logic [2:0]                    in_opcode,
  input  logic [dcps_pkg::FIELD_W-1:0]  in_c [dcps_pkg::MAXD],
  output logic                          out_strobe,
  output logic                          out_answer,
  output logic                          out_overflow,
  output logic                          out_is_empty,
  output logic                          out_is_full,
  output logic                          out_entry_valid,
  output logic [dcps_pkg::FIELD_W-1:0]  out_e [dcps_pkg::MAXD],
  output logic                          out_last
);
  import dcps_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = DIMS * COORD_BITS;
  localparam logic [COORD_BITS-1:0] INF = '1;

  typedef logic [PW-1:0] pt_t;

  // memory read address is scan index, write address separate
  pt_t mem [CAPACITY];
  pt_t rd_r;
  pt_t q_r, ins_r;
  logic [2:0] op_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] ri_r;       // read index issued
  logic          rv_r;       // rd_r holds entry
  logic [CW-1:0] wi_r;       // write index during compaction
  logic          hit_r, found_r;
  logic [CW-1:0] rem_r;
  logic          ins_done_r;
  logic          wrote_r;    // compaction pass was run for this insert
  // pending listing result, held until the next match or the scan end so last can be known
  logic          pend_r;
  pt_t           pend_pt_r;

  function automatic logic dom(pt_t p, pt_t q, logic [3:0] m);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < DIMS; i++) begin
      if (m[i]) begin
        if (p[i*COORD_BITS +: COORD_BITS] < q[i*COORD_BITS +: COORD_BITS]) ok = 1'b0;
      end else begin
        if (q[i*COORD_BITS +: COORD_BITS] < p[i*COORD_BITS +: COORD_BITS]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic logic lexless(pt_t a, pt_t b);
    logic r, dec;
    r = 1'b0;
    dec = 1'b0;
    for (int i = 0; i < DIMS; i++) begin
      if (!dec && a[i*COORD_BITS +: COORD_BITS] != b[i*COORD_BITS +: COORD_BITS]) begin
        dec = 1'b1;
        r = a[i*COORD_BITS +: COORD_BITS] < b[i*COORD_BITS +: COORD_BITS];
      end
    end
    return r;
  endfunction

  pt_t qin;
  always_comb begin
    qin = '0;
    for (int i = 0; i < DIMS; i++) begin
      qin[i*COORD_BITS +: COORD_BITS] = in_c[i][COORD_BITS-1:0];
      if (in_opcode == OP_UPWARD && mask[i]) qin[i*COORD_BITS +: COORD_BITS] = INF;
      if (in_opcode == OP_STATUS)
        qin[i*COORD_BITS +: COORD_BITS] = mask[i] ? INF : '0;
    end
  end

  logic is_list;
  assign is_list = (op_r == OP_LISTDOM) || (op_r == OP_LISTALL);
  assign sts.is_list = is_list;

  logic sd, sq;  // stored dominates query, query dominates stored
  assign sd = dom(rd_r, q_r, mask);
  assign sq = dom(q_r, rd_r, mask);
  logic match;
  assign match = rv_r && ((op_r == OP_LISTALL) || sd);

  // scan is done in the cycle after the last read entry was evaluated
  logic scan_end;
  assign scan_end = cmd.scan_step && (ri_r >= cnt_r) && !rv_r;
  assign sts.scan_done = scan_end;

  logic has_room;
  assign has_room = ({1'b0, cnt_r} - {1'b0, rem_r} + 1'b1) <= (CW+1)'(CAPACITY);
  assign do_write = (op_r == OP_INSERT) && !hit_r && has_room;

  // compaction: stream entries, drop dominated, place insert before first larger
  logic cend;
  assign cend = cmd.compact && (ri_r >= cnt_r) && !rv_r;
  assign sts.compact_done = cend;

  // the insert point is written ahead of a larger entry: that entry is
  // then held back, so the read pointer stalls while the insert is written
  logic stall_ins;
  assign stall_ins = cmd.compact && rv_r && !sq && !ins_done_r && lexless(ins_r, rd_r);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      q_r <= qin;
      ins_r <= qin;
      op_r <= in_opcode;
    end
    if (!stall_ins && ri_r < CW'(CAPACITY)) rd_r <= mem[ri_r[IW-1:0]];
    if (cmd.compact) begin
      if (rv_r && !sq) begin
        if (!ins_done_r && lexless(ins_r, rd_r)) mem[wi_r[IW-1:0]] <= ins_r;
        else mem[wi_r[IW-1:0]] <= rd_r;
      end else if (cend && !ins_done_r) mem[wi_r[IW-1:0]] <= ins_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ri_r <= '0;
      rv_r <= 1'b0;
      wi_r <= '0;
      hit_r <= 1'b0;
      rem_r <= '0;
      ins_done_r <= 1'b0;
      wrote_r <= 1'b0;
      found_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        ri_r <= '0;
        rv_r <= 1'b0;
        wi_r <= '0;
        ins_done_r <= 1'b0;
        // a scan start without a new word opens the compaction pass
        wrote_r <= !cmd.latch;
        if (cmd.latch) begin
          hit_r <= 1'b0;
          rem_r <= '0;
          found_r <= 1'b0;
          pend_r <= 1'b0;
        end
      end else if (cmd.scan_step) begin
        if (rv_r) begin
          if (sd) hit_r <= 1'b1;
          if (sq) rem_r <= rem_r + 1'b1;
          if (match) begin
            found_r <= 1'b1;
            pend_r <= 1'b1;
          end
        end
        if (scan_end) pend_r <= 1'b0;
        if (ri_r < cnt_r) begin
          ri_r <= ri_r + 1'b1;
          rv_r <= 1'b1;
        end else rv_r <= 1'b0;
      end else if (cmd.compact) begin
        if (stall_ins) begin
          ins_done_r <= 1'b1;
          wi_r <= wi_r + 1'b1;
        end else begin
          if (rv_r && !sq) wi_r <= wi_r + 1'b1;
          if (cend && !ins_done_r) begin
            ins_done_r <= 1'b1;
            wi_r <= wi_r + 1'b1;
          end
          if (ri_r < cnt_r) begin
            ri_r <= ri_r + 1'b1;
            rv_r <= 1'b1;
          end else rv_r <= 1'b0;
        end
        if (cend) cnt_r <= cnt_nxt;
      end
    end
  end

  assign cnt_nxt = ins_done_r ? wi_r : wi_r + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.scan_step && rv_r && match) pend_pt_r <= rd_r;
  end

  // result drive
  always_comb begin
    out_strobe = 1'b0;
    out_answer = 1'b0;
    out_overflow = 1'b0;
    out_is_empty = 1'b0;
    out_is_full = 1'b0;
    out_entry_valid = 1'b0;
    out_last = 1'b0;
    for (int i = 0; i < MAXD; i++) out_e[i] = '0;
    if (cmd.scan_step && is_list) begin
      // flush the held entry when a newer match arrives or the scan ends
      if (pend_r && (match || scan_end)) begin
        out_strobe = 1'b1;
        out_entry_valid = 1'b1;
        out_last = scan_end && !match;
        for (int i = 0; i < DIMS; i++)
          out_e[i] = FIELD_W'(pend_pt_r[i*COORD_BITS +: COORD_BITS]);
      end else if (scan_end && !match && !found_r) begin
        out_strobe = 1'b1;
        out_last = 1'b1;
      end
    end
    if (cmd.reply) begin
      out_strobe = 1'b1;
      out_last = 1'b1;
      unique case (op_r) inside
        OP_INSERT: begin
          out_answer = wrote_r;
          out_overflow = !hit_r && !wrote_r;
        end
        OP_CONTAINS, OP_UPWARD: out_answer = hit_r;
        OP_STATUS: begin
          out_is_empty = (cnt_r == '0);
          out_is_full = hit_r;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/dominance_closure_point_store.sv =====
// top level of the dominance closure point store
// usage: pulse start with in_opcode and in_coord0..3 while busy is low; the
// word is taken at that edge and busy rises. each result word appears for one
// cycle with out_strobe high; out_last marks the final word of a request.
// the receiver cannot stall, so no result is ever held back.
// flow: every request scans the stored points once; single-word requests add
// a decide and a reply state; an insert that changes the store adds a
// compaction pass, whose read stalls while the new point is written ahead of
// a stored one. a new request is taken only once busy is low again; the
// memory read port reads one entry per cycle outside that stall.
// listings send one word per matching point, in ascending order, the last one
// flagged; with no match one empty word flagged last.
// cfg_we/cfg_wdata write downward_mask; write only while busy is low.
// reset (rst_n low, synchronous) empties the store and clears the mask;
// memory contents need no clearing since only entries below count are read.
module dominance_closure_point_store #(
  parameter int DIMS       = dcps_pkg::DIMS_DEF,
  parameter int COORD_BITS = dcps_pkg::COORD_BITS_DEF,
  parameter int CAPACITY   = dcps_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [15:0] in_coord0,
  input  logic [15:0] in_coord1,
  input  logic [15:0] in_coord2,
  input  logic [15:0] in_coord3,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  output logic        out_strobe,
  output logic        out_answer,
  output logic        out_overflow,
  output logic        out_is_empty,
  output logic        out_is_full,
  output logic        out_entry_valid,
  output logic [15:0] out_entry0,
  output logic [15:0] out_entry1,
  output logic [15:0] out_entry2,
  output logic [15:0] out_entry3,
  output logic        out_last
);
  import dcps_pkg::*;

  logic [3:0] mask_r;
  dcps_cmd_t cmd;
  dcps_sts_t sts;
  logic do_write;
  logic [FIELD_W-1:0] c [MAXD];
  logic [FIELD_W-1:0] e [MAXD];

  // mask bits beyond the dimension count are ignored by the tests
  always_ff @(posedge clk) begin
    if (!rst_n) mask_r <= '0;
    else if (cfg_we) mask_r <= cfg_wdata;
  end

  assign c[0] = in_coord0;
  assign c[1] = in_coord1;
  assign c[2] = in_coord2;
  assign c[3] = in_coord3;

  dcps_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .sts(sts),
    .do_write(do_write), .cmd(cmd), .busy(busy)
  );

  dcps_dp #(.DIMS(DIMS), .COORD_BITS(COORD_BITS), .CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .do_write(do_write),
    .mask(mask_r), .in_opcode(in_opcode), .in_c(c),
    .out_strobe(out_strobe), .out_answer(out_answer), .out_overflow(out_overflow),
    .out_is_empty(out_is_empty), .out_is_full(out_is_full),
    .out_entry_valid(out_entry_valid), .out_e(e), .out_last(out_last)
  );

  assign out_entry0 = e[0];
  assign out_entry1 = e[1];
  assign out_entry2 = e[2];
  assign out_entry3 = e[3];

  // result words only come while a request is in progress
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy) else $error("result word while idle");
  a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_strobe) else $error("last without strobe");
  a_ovf_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_answer && out_overflow)) else $error("answer with overflow");
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised");
endmodule

// ===== test/dcps_checker.sv =====
// checker for the dominance closure point store: predicts every result word and compares
module dcps_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [15:0] in_coord0,
  input  logic [15:0] in_coord1,
  input  logic [15:0] in_coord2,
  input  logic [15:0] in_coord3,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        out_strobe,
  input  logic        out_answer,
  input  logic        out_overflow,
  input  logic        out_is_empty,
  input  logic        out_is_full,
  input  logic        out_entry_valid,
  input  logic [15:0] out_entry0,
  input  logic [15:0] out_entry1,
  input  logic [15:0] out_entry2,
  input  logic [15:0] out_entry3,
  input  logic        out_last,
  output int          fail_count,
  output int          pending,
  output int          words_seen,
  output int          overflow_seen
);
  import dcps_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam logic [15:0] INF = 16'hffff;

  typedef logic [3:0][15:0] point_t;

  typedef struct packed {
    logic   answer;
    logic   overflow;
    logic   is_empty;
    logic   is_full;
    logic   entry_valid;
    point_t entry;
    logic   last;
  } reply_t;

  point_t     front [CAP];
  int         front_len;
  logic [3:0] dmask;
  reply_t     expected_replies [$];

  function automatic void queue_word(reply_t r);
    expected_replies = {expected_replies, r};
  endfunction

  function automatic bit covers(point_t p, point_t q, logic [3:0] m);
    for (int i = 0; i < MAXD; i++) begin
      if (m[i]) begin
        if (p[i] < q[i]) return 0;
      end else begin
        if (q[i] < p[i]) return 0;
      end
    end
    return 1;
  endfunction

  function automatic bit lex_below(point_t a, point_t b);
    for (int i = 0; i < MAXD; i++) begin
      if (a[i] < b[i]) return 1;
      if (b[i] < a[i]) return 0;
    end
    return 0;
  endfunction

  function automatic bit in_closure(point_t q);
    for (int k = 0; k < front_len; k++)
      if (covers(front[k], q, dmask)) return 1;
    return 0;
  endfunction

  task automatic predict_word(logic [2:0] op, point_t q);
    reply_t r;
    point_t probe;
    int removed;
    int w;
    int pos;
    int n;
    r = '0;
    r.last = 1'b1;
    case (op)
      OP_INSERT: begin
        removed = 0;
        r.answer = 1'b1;
        for (int k = 0; k < front_len; k++) begin
          if (covers(front[k], q, dmask)) r.answer = 1'b0;
          if (covers(q, front[k], dmask)) removed++;
        end
        if (r.answer && front_len - removed + 1 > CAP) begin
          r.answer = 1'b0;
          r.overflow = 1'b1;
        end
        if (r.answer) begin
          w = 0;
          for (int k = 0; k < front_len; k++) begin
            if (!covers(q, front[k], dmask)) begin
              front[w] = front[k];
              w++;
            end
          end
          pos = w;
          while (pos > 0 && lex_below(q, front[pos-1])) begin
            front[pos] = front[pos-1];
            pos--;
          end
          front[pos] = q;
          front_len = w + 1;
        end
        queue_word(r);
      end
      OP_CONTAINS: begin
        r.answer = in_closure(q);
        queue_word(r);
      end
      OP_UPWARD: begin
        probe = q;
        for (int i = 0; i < MAXD; i++) if (dmask[i]) probe[i] = INF;
        r.answer = in_closure(probe);
        queue_word(r);
      end
      OP_STATUS: begin
        for (int i = 0; i < MAXD; i++) probe[i] = dmask[i] ? INF : 16'd0;
        r.is_empty = (front_len == 0);
        r.is_full = in_closure(probe);
        queue_word(r);
      end
      OP_LISTDOM, OP_LISTALL: begin
        n = 0;
        for (int k = 0; k < front_len; k++) begin
          if (op == OP_LISTALL || covers(front[k], q, dmask)) n++;
        end
        if (n == 0) queue_word(r);
        for (int k = 0; k < front_len; k++) begin
          if (op == OP_LISTALL || covers(front[k], q, dmask)) begin
            n--;
            r.entry_valid = 1'b1;
            r.entry = front[k];
            r.last = (n == 0);
            queue_word(r);
          end
        end
      end
      // unused codes: one bare word flagged last
      default: queue_word(r);
    endcase
  endtask

  reply_t got;
  reply_t want;
  assign got = '{out_answer, out_overflow, out_is_empty, out_is_full, out_entry_valid,
                 {out_entry3, out_entry2, out_entry1, out_entry0}, out_last};
  assign pending = expected_replies.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      front_len = 0;
      dmask = '0;
      expected_replies.delete();
      fail_count <= 0;
      words_seen <= 0;
      overflow_seen <= 0;
    end else begin
      if (cfg_we) dmask = cfg_wdata;
      if (start && !busy)
        predict_word(in_opcode, {in_coord3, in_coord2, in_coord1, in_coord0});
      if (out_strobe) begin
        words_seen <= words_seen + 1;
        if (out_overflow) overflow_seen <= overflow_seen + 1;
        if (expected_replies.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_replies.pop_front();
          if (want !== got) begin
            if (fail_count < 10) $display("mismatch: expected %p actual %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== test/tb_top.sv =====
// stimulus and verdict for the dominance closure point store
module tb_top;
  import dcps_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_opcode = '0;
  logic [15:0] in_coord0 = '0;
  logic [15:0] in_coord1 = '0;
  logic [15:0] in_coord2 = '0;
  logic [15:0] in_coord3 = '0;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = '0;
  logic        out_strobe, out_answer, out_overflow, out_is_empty, out_is_full;
  logic        out_entry_valid, out_last;
  logic [15:0] out_entry0, out_entry1, out_entry2, out_entry3;
  int          fail_count, pending, words_seen, overflow_seen;
  int          words_sent = 0;
  int          stall_cycles = 0;
  logic [3:0]  mask_now = '0;
  bit          allow_gaps = 1'b1;

  always #1 clk = ~clk;

  dominance_closure_point_store i_dut (.*);

  dcps_checker i_checker (.*);

  // watchdog: any accepted word or result word counts as progress
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || !rst_n) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("dominance_closure_point_store verification failed");
      $finish;
    end
  end

  // hold start until the block takes the word, then maybe leave a gap
  task automatic send_word(logic [2:0] op, logic [15:0] c0, logic [15:0] c1,
                           logic [15:0] c2, logic [15:0] c3);
    start <= 1'b1;
    in_opcode <= op;
    in_coord0 <= c0;
    in_coord1 <= c1;
    in_coord2 <= c2;
    in_coord3 <= c3;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    words_sent++;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // mask changes only once the block has gone quiet
  task automatic write_mask(logic [3:0] m);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    mask_now = m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // pick a coordinate: extremes, a small cluster, or anything
  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      2, 3: return 16'($urandom_range(0, 40));
      default: return 16'($urandom);
    endcase
  endfunction

  // cost-space antichain point (sum fixed), mirrored in downward dimensions so
  // that inserts of distinct points tend not to cover each other
  task automatic chain_point(int spread, output logic [15:0] c [4]);
    int r;
    r = $urandom_range(0, spread);
    c[0] = 16'(r);
    c[1] = 16'(spread - r);
    c[2] = 16'($urandom_range(0, 1));
    c[3] = 16'($urandom_range(0, 1));
    for (int i = 0; i < 4; i++) if (mask_now[i]) c[i] = ~c[i];
  endtask

  task automatic random_phase(int count, int insert_pct);
    logic [15:0] c [4];
    logic [2:0]  op;
    int          pick;
    for (int n = 0; n < count; n++) begin
      chain_point(50, c);
      pick = $urandom_range(0, 99);
      if (pick < insert_pct) op = OP_INSERT;
      else if (pick < 96) op = 3'($urandom_range(OP_CONTAINS, OP_LISTALL));
      else op = 3'($urandom_range(0, 7));
      // some noise: fully random coordinates, or nudged chain points
      case ($urandom_range(0, 5))
        0: for (int i = 0; i < 4; i++) c[i] = pick_coord();
        1: c[$urandom_range(0, 3)] ^= 16'(1 << $urandom_range(0, 15));
        default: ;
      endcase
      send_word(op, c[0], c[1], c[2], c[3]);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-store answers, extremes, equal and covered inserts
    send_word(OP_STATUS, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_word(OP_LISTALL, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_word(OP_LISTDOM, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_word(OP_CONTAINS, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_word(OP_INSERT, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_word(OP_INSERT, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_word(OP_INSERT, 16'h0005, 16'h0009, 16'hffff, 16'h0000);
    send_word(OP_INSERT, 16'h0009, 16'h0005, 16'h0000, 16'hffff);
    send_word(OP_INSERT, 16'h0009, 16'h0009, 16'h0000, 16'hffff);
    send_word(OP_CONTAINS, 16'h0009, 16'h0009, 16'hffff, 16'hffff);
    send_word(OP_UPWARD, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_word(OP_LISTDOM, 16'h0009, 16'h0009, 16'hffff, 16'hffff);
    // this one covers everything stored so far
    send_word(OP_INSERT, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_word(OP_STATUS, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_word(OP_LISTALL, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_word(3'd6, 16'h1234, 16'h0000, 16'h0000, 16'h0000);
    send_word(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);

    // all-downward mask on the left-over store, then fill it to overflow
    write_mask(4'hf);
    send_word(OP_STATUS, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_word(OP_UPWARD, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    random_phase(60, 85);

    write_mask(4'h5);
    random_phase(50, 55);
    write_mask(4'ha);
    random_phase(50, 55);
    write_mask(4'($urandom_range(1, 14)));
    random_phase(30, 55);

    // last stretch back-to-back, no gaps
    write_mask(4'h0);
    allow_gaps = 1'b0;
    random_phase(40, 70);
    start <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d request words, checked %0d result words (%0d overflow)",
             words_sent, words_seen, overflow_seen);
    $display("masks 0, f, 5, a, a random one and 0 again; mismatches %0d", fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("dominance_closure_point_store verification clean");
    end else begin
      $display("dominance_closure_point_store verification failed");
    end
    $finish;
  end
endmodule

// ===== dominance_closure_point_store.f =====
rtl/dcps_pkg.sv
rtl/dcps_ctrl.sv
rtl/dcps_dp.sv
rtl/dominance_closure_point_store.sv
test/dcps_checker.sv
test/tb_top.sv
